// ===== sv/ppfc_pkg.sv =====
// ----------------------------------------------------------------------------
// ppfc_pkg: shared types and constants for the packed pixel format converter
// Holds the payload structs, the configuration bundle, register indexes,
// depth codes and the keying threshold function.
// ----------------------------------------------------------------------------
`default_nettype none

package ppfc_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_PIXEL_DEPTHS     = 3'd0;
  localparam logic [2:0] REG_SRC_CHANNEL_BITS = 3'd1;
  localparam logic [2:0] REG_SRC_CHANNEL_POS  = 3'd2;
  localparam logic [2:0] REG_DST_CHANNEL_BITS = 3'd3;
  localparam logic [2:0] REG_DST_CHANNEL_POS  = 3'd4;
  localparam logic [2:0] REG_KEY_ENABLE       = 3'd5;
  localparam logic [2:0] REG_ALPHA_MAX_SHIFT  = 3'd6;
  localparam logic [2:0] REG_KEY_VALUE        = 3'd7;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // pixel depth codes
  localparam logic [1:0] DEPTH_8  = 2'd0;
  localparam logic [1:0] DEPTH_16 = 2'd1;
  localparam logic [1:0] DEPTH_24 = 2'd2;
  localparam logic [1:0] DEPTH_32 = 2'd3;

  localparam logic [3:0] PIXEL_DEPTHS_RST = 4'd5;

  // channel slots
  localparam int unsigned CH_R = 0;
  localparam int unsigned CH_G = 1;
  localparam int unsigned CH_B = 2;
  localparam int unsigned CH_A = 3;

  typedef struct packed {
    logic [31:0] pixel_bytes;
    logic        last_pixel;
  } ppfc_in_t;

  typedef struct packed {
    logic [31:0] out_bytes;
    logic [2:0]  out_byte_count;
    logic        out_last;
  } ppfc_out_t;

  typedef struct packed {
    logic [3:0]  pixel_depths;
    logic [23:0] src_channel_bits;
    logic [19:0] src_channel_pos;
    logic [23:0] dst_channel_bits;
    logic [19:0] dst_channel_pos;
    logic        key_enable;
    logic [3:0]  alpha_max_shift;
    logic [31:0] key_value;
  } ppfc_cfg_t;

  // one classified pixel between front and back
  typedef struct packed {
    logic [3:0][31:0] chan;
    logic             alpha_copy;
    logic             keyed;
    logic             last;
  } ppfc_work_t;

  // keying threshold from the alpha max shift
  function automatic logic [6:0] key_threshold(input logic [3:0] shift);
    logic [7:0] m;
    logic [7:0] thr;
    m   = (shift < 4'd8) ? (8'hff >> shift) : 8'h00;
    thr = ((m & 8'hfe) < 8'd3) ? 8'd1 : (m >> 1);
    return thr[6:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/ppfc_front.sv =====
// ----------------------------------------------------------------------------
// ppfc_front: pixel assembly and channel extraction
// Builds the source word from the input bytes, pulls out the four channels
// and decides how alpha will be handled for this pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module ppfc_front (
  input  ppfc_pkg::ppfc_cfg_t  cfg,
  input  ppfc_pkg::ppfc_in_t   in_item,
  output ppfc_pkg::ppfc_work_t work
);
  import ppfc_pkg::*;

  logic [31:0] pixel;
  logic [6:0]  thr;
  logic        has_alpha;

  always_comb begin
    unique case (cfg.pixel_depths[1:0])
      DEPTH_8:  pixel = {24'h0, in_item.pixel_bytes[7:0]};
      DEPTH_16: pixel = {16'h0, in_item.pixel_bytes[15:0]};
      DEPTH_24: pixel = {8'h0, in_item.pixel_bytes[7:0], in_item.pixel_bytes[15:8],
                         in_item.pixel_bytes[23:16]};
      default:  pixel = in_item.pixel_bytes;
    endcase
  end

  assign thr       = key_threshold(cfg.alpha_max_shift);
  assign has_alpha = (cfg.src_channel_bits[23:18] != 6'd0);

  // mask of a w-bit channel: all ones shifted right by (-w) mod 32
  always_comb begin
    logic [4:0] pos;
    logic [4:0] msh;
    for (int i = 0; i < 4; i++) begin
      pos = cfg.src_channel_pos[5*i +: 5];
      msh = 5'd0 - cfg.src_channel_bits[6*i +: 5];
      work.chan[i] = (pixel >> pos) & (32'hffff_ffff >> msh);
    end
    work.alpha_copy = has_alpha && !cfg.key_enable;
    work.keyed      = has_alpha && cfg.key_enable && (work.chan[CH_A] < {25'h0, thr});
    work.last       = in_item.last_pixel;
  end

endmodule

`default_nettype wire

// ===== sv/ppfc_queue.sv =====
// ----------------------------------------------------------------------------
// ppfc_queue: small register queue between front and back
// First-in first-out store of classified pixels; full drops the write ready.
// ----------------------------------------------------------------------------
`default_nettype none

module ppfc_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  ppfc_pkg::ppfc_work_t  push_data,
  output logic                  not_full,
  input  wire                   pop,
  output ppfc_pkg::ppfc_work_t  head,
  output logic                  not_empty
);
  import ppfc_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ppfc_work_t           mem_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;

  assign not_full  = (count_r != CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ppfc_back.sv =====
// ----------------------------------------------------------------------------
// ppfc_back: channel rescaling, placement, keying and output packing
// Takes the queue head, builds the destination word and holds it in the
// output register until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ppfc_back (
  input  wire                   clk,
  input  wire                   rst_n,
  input  ppfc_pkg::ppfc_cfg_t   cfg,
  input  ppfc_pkg::ppfc_work_t  work,
  input  wire                   work_valid,
  output logic                  work_pop,
  output logic                  out_valid,
  input  wire                   out_ready,
  output ppfc_pkg::ppfc_out_t   out_data
);
  import ppfc_pkg::*;

  logic             out_valid_r, out_valid_nxt;
  ppfc_out_t        out_data_r, out_data_nxt;
  logic [3:0]       left;
  logic [3:0][31:0] scaled;
  logic [31:0]      o;
  logic [31:0]      word;

  // shift direction per channel: left when src width does not exceed dst width
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      left[i] = (cfg.src_channel_bits[6*i +: 6] <= cfg.dst_channel_bits[6*i +: 6]);
    end
  end

  always_comb begin
    logic [4:0] d;
    logic       dir;
    for (int i = 0; i < 4; i++) begin
      d   = cfg.src_channel_bits[6*i +: 5] - cfg.dst_channel_bits[6*i +: 5];
      // blue follows the red direction
      dir = (i == CH_B) ? left[CH_R] : left[i];
      scaled[i] = dir ? (work.chan[i] << (5'd0 - d)) : (work.chan[i] >> d);
    end
  end

  always_comb begin
    o = (scaled[CH_G] << cfg.dst_channel_pos[5*CH_G +: 5])
      | (scaled[CH_B] << cfg.dst_channel_pos[5*CH_B +: 5])
      | (scaled[CH_R] << cfg.dst_channel_pos[5*CH_R +: 5]);
    if (work.alpha_copy) begin
      o = o | (scaled[CH_A] << cfg.dst_channel_pos[5*CH_A +: 5]);
    end
    if (work.keyed) begin
      o = cfg.key_value;
    end
  end

  always_comb begin
    unique case (cfg.pixel_depths[3:2])
      DEPTH_8:  word = {24'h0, o[7:0]};
      DEPTH_16: word = {16'h0, o[15:0]};
      DEPTH_24: word = {8'h0, o[7:0], o[15:8], o[23:16]};
      default:  word = o;
    endcase
  end

  assign work_pop = work_valid && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (work_pop) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.out_bytes      = word;
      out_data_nxt.out_byte_count = {1'b0, cfg.pixel_depths[3:2]} + 3'd1;
      out_data_nxt.out_last       = work.last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== sv/packed_pixel_format_converter.sv =====
// ----------------------------------------------------------------------------
// packed_pixel_format_converter: packed pixel format converter top level
// Converts one packed source pixel per item into one packed destination
// pixel, with per-channel rescaling and optional alpha keying.
// ----------------------------------------------------------------------------
// usage
//   in_*   : valid/ready channel, one source pixel (bytes + row end flag)
//   out_*  : valid/ready channel, one destination pixel per input item
//   cfg_*  : plain write port, cfg_index selects the register, no wait
// an accepted item is written into the queue, and the back moves it from
//   the queue head into the output register that drives out_*
// throughput: one item per cycle while the output register is free or
//   being taken, since the back stage drains the queue into it
// stall: when out_ready is low the output register holds, the queue soaks
//   up QUEUE_DEPTH more items, then in_ready drops until the receiver
//   takes a result
// reset: synchronous, active low; queue and output register are emptied and
//   the registers return to their defaults (16-bit source, 16-bit dest,
//   every width and position zero, keying off)
// configuration, which the block does not guard, must be written by the user only while no item is in flight
// ----------------------------------------------------------------------------
`default_nettype none

module packed_pixel_format_converter #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire                  clk,
  input  wire                  rst_n,
  // source pixels
  input  wire                  in_valid,
  output logic                 in_ready,
  input  ppfc_pkg::ppfc_in_t   in_data,
  // destination pixels
  output logic                 out_valid,
  input  wire                  out_ready,
  output ppfc_pkg::ppfc_out_t  out_data,
  // configuration writes
  input  wire                  cfg_we,
  input  wire [ppfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [ppfc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ppfc_pkg::*;

  ppfc_cfg_t  cfg_r, cfg_nxt;
  ppfc_work_t front_work;
  ppfc_work_t q_head;
  logic       q_not_full;
  logic       q_not_empty;
  logic       q_pop;
  logic       in_fire;

  // ---------------------------------------------------------------- registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_PIXEL_DEPTHS:     cfg_nxt.pixel_depths     = cfg_wdata[3:0];
        REG_SRC_CHANNEL_BITS: cfg_nxt.src_channel_bits = cfg_wdata[23:0];
        REG_SRC_CHANNEL_POS:  cfg_nxt.src_channel_pos  = cfg_wdata[19:0];
        REG_DST_CHANNEL_BITS: cfg_nxt.dst_channel_bits = cfg_wdata[23:0];
        REG_DST_CHANNEL_POS:  cfg_nxt.dst_channel_pos  = cfg_wdata[19:0];
        REG_KEY_ENABLE:       cfg_nxt.key_enable       = cfg_wdata[0];
        REG_ALPHA_MAX_SHIFT:  cfg_nxt.alpha_max_shift  = cfg_wdata[3:0];
        REG_KEY_VALUE:        cfg_nxt.key_value        = cfg_wdata;
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_depths     <= PIXEL_DEPTHS_RST;
      cfg_r.src_channel_bits <= '0;
      cfg_r.src_channel_pos  <= '0;
      cfg_r.dst_channel_bits <= '0;
      cfg_r.dst_channel_pos  <= '0;
      cfg_r.key_enable       <= 1'b0;
      cfg_r.alpha_max_shift  <= '0;
      cfg_r.key_value        <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // ---------------------------------------------------------------- front
  // input is taken whenever the queue has room, independent of the output
  assign in_ready = q_not_full;
  assign in_fire  = in_valid && in_ready;

  ppfc_front u_front (
    .cfg     (cfg_r),
    .in_item (in_data),
    .work    (front_work)
  );

  // ---------------------------------------------------------------- queue
  ppfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_data (front_work),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty)
  );

  // ---------------------------------------------------------------- back
  ppfc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .work       (q_head),
    .work_valid (q_not_empty),
    .work_pop   (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

// ===== sv/ppfc_chk.sv =====
// ----------------------------------------------------------------------------
// ppfc_chk: port-level checks for the packed pixel format converter
// Watches the top level's ports and is attached to it by a bind.
// ----------------------------------------------------------------------------
`default_nettype none

module ppfc_chk (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_ready,
  input wire                  out_valid,
  input wire                  out_ready,
  input ppfc_pkg::ppfc_out_t  out_data
);
  import ppfc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // input backpressure only while a result is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  a_byte_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.out_byte_count == 3'd1 || out_data.out_byte_count == 3'd2 ||
                   out_data.out_byte_count == 3'd3 || out_data.out_byte_count == 3'd4))
    else $error("byte count out of range");

  // the unused upper byte of a three-byte pixel is zero
  a_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_byte_count == 3'd3 |-> out_data.out_bytes[31:24] == 8'h00)
    else $error("upper byte set for a three-byte pixel");

endmodule

bind packed_pixel_format_converter ppfc_chk u_ppfc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
